// ===== rtl/core/pih_pkg.sv =====
// shared constants, codes and types of the point-in-figures hit test
package pih_pkg;

    localparam int MAX_FIGURES_DEF = 16;
    localparam int COORD_WIDTH_DEF = 24;

    localparam int RESULT_CAP  = 16;
    localparam int HIT_CNT_W   = $clog2(RESULT_CAP + 1);
    localparam int POINT_W     = 16;
    localparam int FIG_IDX_W   = 4;
    localparam int MODE_W      = 2;

    localparam logic [MODE_W-1:0] MODE_RECT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CIRCLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        OP_DX = 2'd0,
        OP_DY = 2'd1,
        OP_R  = 2'd2
    } op_sel_t;

    typedef struct packed {
        logic    capture;
        logic    mul_en;
        op_sel_t op_sel;
        logic    sum_load;
        logic    sum_add;
    } arith_ctl_t;

endpackage

// ===== rtl/core/pih_fig_mem.sv =====
// figure table: one write port, one registered read port
module pih_fig_mem #(
    parameter int DEPTH  = pih_pkg::MAX_FIGURES_DEF,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 4 * pih_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/pih_arith.sv =====
// shared square-and-accumulate unit for the circle test
module pih_arith #(
    parameter int COORD_WIDTH = pih_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  pih_pkg::arith_ctl_t           ctl,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    output logic                          in_circle
);

    localparam int W      = COORD_WIDTH;
    localparam int PROD_W = 2 * W;
    localparam int SUM_W  = 2 * W + 1;

    logic [W:0]        dx_diff, dx_neg, dy_diff, dy_neg, bx_ext, bx_neg;
    logic [W-1:0]      dx_mag, dy_mag, r_mag;
    logic [W-1:0]      dx_reg, dy_reg, r_reg;
    logic [W-1:0]      mul_op;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg;

    // absolute differences and radius magnitude
    assign dx_diff = {ax[W-1], ax} - {px[W-1], px};
    assign dy_diff = {ay[W-1], ay} - {py[W-1], py};
    assign bx_ext  = {bx[W-1], bx};
    assign dx_neg  = -dx_diff;
    assign dy_neg  = -dy_diff;
    assign bx_neg  = -bx_ext;
    assign dx_mag  = dx_diff[W] ? dx_neg[W-1:0] : dx_diff[W-1:0];
    assign dy_mag  = dy_diff[W] ? dy_neg[W-1:0] : dy_diff[W-1:0];
    assign r_mag   = bx_ext[W] ? bx_neg[W-1:0] : bx_ext[W-1:0];

    always_comb begin
        case (ctl.op_sel)
            pih_pkg::OP_DX: mul_op = dx_reg;
            pih_pkg::OP_DY: mul_op = dy_reg;
            pih_pkg::OP_R:  mul_op = r_reg;
            default:        mul_op = r_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            dx_reg <= dx_mag;
            dy_reg <= dy_mag;
            r_reg  <= r_mag;
        end
        if (ctl.mul_en) begin
            prod_reg <= PROD_W'(mul_op) * PROD_W'(mul_op);
        end
        if (ctl.sum_load) begin
            sum_reg <= {1'b0, prod_reg};
        end else if (ctl.sum_add) begin
            sum_reg <= sum_reg + {1'b0, prod_reg};
        end
    end

    // prod_reg holds r squared when this is read
    assign in_circle = sum_reg < {1'b0, prod_reg};

endmodule

// ===== rtl/core/point_in_figures_hit_test_top.sv =====
// point-in-figures hit test: figure table, scan sequencer and result register
// Loads (rectangle or circle) fill the table in order; loads past MAX_FIGURES
// are dropped. A query holds s_ready low while it scans the table: a rectangle
// takes a table read and four compares, a circle a table read, difference
// capture, three passes through the one shared multiplier and a compare, and
// each hit a further step to queue its result, longer if m_ready is low. A query
// of an empty table goes straight to its not-found result. The scan time is set
// by the single table read port and the shared multiplier. One result is shown
// per transfer, the last one marked; the result register lets the next item in
// while the final result still waits.
module point_in_figures_hit_test_top #(
    parameter int MAX_FIGURES = pih_pkg::MAX_FIGURES_DEF,
    parameter int COORD_WIDTH = pih_pkg::COORD_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pih_pkg::MODE_W-1:0]      s_mode,
    input  logic signed [COORD_WIDTH-1:0]   s_x_a,
    input  logic signed [COORD_WIDTH-1:0]   s_y_a,
    input  logic signed [COORD_WIDTH-1:0]   s_x_b,
    input  logic signed [COORD_WIDTH-1:0]   s_y_b,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pih_pkg::POINT_W-1:0]     m_point_index,
    output logic [pih_pkg::FIG_IDX_W-1:0]   m_figure_index,
    output logic                            m_found,
    output logic                            m_last
);

    localparam int W       = COORD_WIDTH;
    localparam int CNT_W   = $clog2(MAX_FIGURES + 1);
    localparam int ADDR_W  = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
    localparam int ENTRY_W = 4 * W + 1;
    localparam int HC_W    = pih_pkg::HIT_CNT_W;
    localparam int FI_W    = pih_pkg::FIG_IDX_W;
    localparam int PI_W    = pih_pkg::POINT_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FETCH = 9'b000000010,
        S_TEST  = 9'b000000100,
        S_SQ_DX = 9'b000001000,
        S_SQ_DY = 9'b000010000,
        S_SQ_R  = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_PUSH  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fig_count_reg, fig_count_next;
    logic [PI_W-1:0]     point_cnt_reg, point_cnt_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [HC_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic signed [W-1:0] px_reg, px_next, py_reg, py_next;
    logic [PI_W-1:0]     idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [FI_W-1:0]     pend_fig_reg, pend_fig_next;

    logic                m_valid_reg, m_valid_next;
    logic [PI_W-1:0]     m_point_index_reg, m_point_index_next;
    logic [FI_W-1:0]     m_figure_index_reg, m_figure_index_next;
    logic                m_found_reg, m_found_next;
    logic                m_last_reg, m_last_next;

    logic                in_xfer, load_item, table_full, out_free, scan_last, cap_hit;
    logic                mem_wr_en, mem_rd_en;
    logic [ENTRY_W-1:0]  mem_wr_data, mem_rd_data;
    logic                fig_circle, rect_hit, circ_hit;
    logic signed [W-1:0] f_ax, f_ay, f_bx, f_by;
    logic signed [W-1:0] wr_by;
    logic [CNT_W+FI_W-1:0] scan_ext;
    logic [FI_W-1:0]     scan_fig;
    pih_pkg::arith_ctl_t arith_ctl;

    assign s_ready   = (state_reg == S_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign load_item = (s_mode == pih_pkg::MODE_RECT) || (s_mode == pih_pkg::MODE_CIRCLE);
    assign table_full = (fig_count_reg >= CNT_W'(MAX_FIGURES));
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_last = ((scan_reg + CNT_W'(1)) == fig_count_reg);
    assign cap_hit   = ((hit_cnt_reg + HC_W'(1)) == HC_W'(pih_pkg::RESULT_CAP));
    assign scan_ext  = {{FI_W{1'b0}}, scan_reg};
    assign scan_fig  = scan_ext[FI_W-1:0];

    // figure table
    assign mem_wr_en   = in_xfer && load_item && !table_full;
    assign wr_by       = (s_mode == pih_pkg::MODE_RECT) ? s_y_b : '0;
    assign mem_wr_data = {(s_mode == pih_pkg::MODE_CIRCLE), s_x_a, s_y_a, s_x_b, wr_by};
    assign mem_rd_en   = (state_reg == S_FETCH);

    pih_fig_mem #(
        .DEPTH  (MAX_FIGURES),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_fig_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (fig_count_reg[ADDR_W-1:0]),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_reg[ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    assign fig_circle = mem_rd_data[ENTRY_W-1];
    assign f_ax       = mem_rd_data[4*W-1:3*W];
    assign f_ay       = mem_rd_data[3*W-1:2*W];
    assign f_bx       = mem_rd_data[2*W-1:W];
    assign f_by       = mem_rd_data[W-1:0];

    assign rect_hit = (px_reg > f_ax) && (px_reg < f_bx) && (py_reg < f_ay) && (py_reg > f_by);

    always_comb begin
        arith_ctl.capture  = 1'b0;
        arith_ctl.mul_en   = 1'b0;
        arith_ctl.op_sel   = pih_pkg::OP_DX;
        arith_ctl.sum_load = 1'b0;
        arith_ctl.sum_add  = 1'b0;
        case (state_reg)
            S_TEST: begin
                arith_ctl.capture = 1'b1;
            end
            S_SQ_DX: begin
                arith_ctl.mul_en = 1'b1;
                arith_ctl.op_sel = pih_pkg::OP_DX;
            end
            S_SQ_DY: begin
                arith_ctl.mul_en   = 1'b1;
                arith_ctl.op_sel   = pih_pkg::OP_DY;
                arith_ctl.sum_load = 1'b1;
            end
            S_SQ_R: begin
                arith_ctl.mul_en  = 1'b1;
                arith_ctl.op_sel  = pih_pkg::OP_R;
                arith_ctl.sum_add = 1'b1;
            end
            default: begin
            end
        endcase
    end

    pih_arith #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_arith (
        .aclk      (aclk),
        .ctl       (arith_ctl),
        .ax        (f_ax),
        .ay        (f_ay),
        .bx        (f_bx),
        .px        (px_reg),
        .py        (py_reg),
        .in_circle (circ_hit)
    );

    // scan sequencer
    always_comb begin
        state_next          = state_reg;
        fig_count_next      = fig_count_reg;
        point_cnt_next      = point_cnt_reg;
        scan_next           = scan_reg;
        hit_cnt_next        = hit_cnt_reg;
        px_next             = px_reg;
        py_next             = py_reg;
        idx_next            = idx_reg;
        pend_valid_next     = pend_valid_reg;
        pend_fig_next       = pend_fig_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_point_index_next  = m_point_index_reg;
        m_figure_index_next = m_figure_index_reg;
        m_found_next        = m_found_reg;
        m_last_next         = m_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    case (s_mode)
                        pih_pkg::MODE_RECT, pih_pkg::MODE_CIRCLE: begin
                            if (!table_full) begin
                                fig_count_next = fig_count_reg + CNT_W'(1);
                            end
                        end
                        pih_pkg::MODE_QUERY: begin
                            px_next         = s_x_a;
                            py_next         = s_y_a;
                            idx_next        = point_cnt_reg;
                            point_cnt_next  = point_cnt_reg + PI_W'(1);
                            scan_next       = '0;
                            hit_cnt_next    = '0;
                            pend_valid_next = 1'b0;
                            state_next = (fig_count_reg == '0) ? S_DONE : S_FETCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                state_next = S_TEST;
            end
            S_TEST: begin
                if (fig_circle) begin
                    state_next = S_SQ_DX;
                end else if (rect_hit) begin
                    state_next = S_PUSH;
                end else if (scan_last) begin
                    state_next = S_DONE;
                end else begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = S_FETCH;
                end
            end
            S_SQ_DX: begin
                state_next = S_SQ_DY;
            end
            S_SQ_DY: begin
                state_next = S_SQ_R;
            end
            S_SQ_R: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (circ_hit) begin
                    state_next = S_PUSH;
                end else if (scan_last) begin
                    state_next = S_DONE;
                end else begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = S_FETCH;
                end
            end
            S_PUSH: begin
                // previous hit goes out once this one proves it was not last
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next        = 1'b1;
                        m_point_index_next  = idx_reg;
                        m_figure_index_next = pend_fig_reg;
                        m_found_next        = 1'b1;
                        m_last_next         = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_fig_next   = scan_fig;
                    hit_cnt_next    = hit_cnt_reg + HC_W'(1);
                    if (scan_last || cap_hit) begin
                        state_next = S_DONE;
                    end else begin
                        scan_next  = scan_reg + CNT_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_point_index_next  = idx_reg;
                    m_figure_index_next = pend_valid_reg ? pend_fig_reg : '0;
                    m_found_next        = pend_valid_reg;
                    m_last_next         = 1'b1;
                    pend_valid_next     = 1'b0;
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fig_count_reg  <= '0;
            point_cnt_reg  <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fig_count_reg  <= fig_count_next;
            point_cnt_reg  <= point_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg           <= scan_next;
        hit_cnt_reg        <= hit_cnt_next;
        px_reg             <= px_next;
        py_reg             <= py_next;
        idx_reg            <= idx_next;
        pend_fig_reg       <= pend_fig_next;
        m_point_index_reg  <= m_point_index_next;
        m_figure_index_reg <= m_figure_index_next;
        m_found_reg        <= m_found_next;
        m_last_reg         <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_point_index  = m_point_index_reg;
    assign m_figure_index = m_figure_index_reg;
    assign m_found        = m_found_reg;
    assign m_last         = m_last_reg;

endmodule

// ===== rtl/core/pih_checker.sv =====
// port-level assertions for the hit test top, bound to it
module pih_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [pih_pkg::MODE_W-1:0]    s_mode,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [pih_pkg::POINT_W-1:0]   m_point_index,
    input logic [pih_pkg::FIG_IDX_W-1:0] m_figure_index,
    input logic                          m_found,
    input logic                          m_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_index)
            && $stable(m_figure_index) && $stable(m_found) && $stable(m_last))
        else $error("result changed while stalled");

    // a not-found result stands alone
    a_miss_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_last && (m_figure_index == '0))
        else $error("not-found result not marked last or has nonzero figure");

    // a query transfer closes the input until the scan ends
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == pih_pkg::MODE_QUERY) |=> !s_ready)
        else $error("input open during query scan");

    // a non-last result means the scan of its point is still running
    a_same_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input open while a non-last result is shown");

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result valid or input closed after reset");

endmodule

bind point_in_figures_hit_test_top pih_checker u_pih_checker (.*);
